>>> rtl/analog_stick_deadzone_octagon_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the stick conditioner
// Shared concurrent check forms used by the top-level conditioner module.
// ----------------------------------------------------------------------------
`ifndef ANALOG_STICK_DEADZONE_OCTAGON_UNIT_ASSERT_SVH
`define ANALOG_STICK_DEADZONE_OCTAGON_UNIT_ASSERT_SVH

// Check that an antecedent implies a consequent at the same edge.
`define ASDO_ASSERT_IMP(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");

// Check that an antecedent implies a consequent at the next edge.
`define ASDO_ASSERT_NXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");

`endif

>>> rtl/asdo_pkg.sv
// ----------------------------------------------------------------------------
// asdo_pkg
// Constants and types for the stick conditioner pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package asdo_pkg;
  localparam int unsigned FracBits  = 16;
  localparam int unsigned FullScale = 85;
  localparam int unsigned RawScale  = 32767;
  localparam int unsigned GateMajor = 69;
  localparam int unsigned GateMinor = 16;
  localparam int unsigned DzWidth   = 7;
  localparam int unsigned CfgIdxW   = 1;
  localparam logic [CfgIdxW-1:0] RegLeftDz  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegRightDz = 1'b1;
  localparam logic [DzWidth-1:0] DzReset    = 7'd16;

  typedef struct packed {
    logic       sel;
    logic       neg_x;
    logic       neg_y;
  } tag_t;
endpackage
`default_nettype wire

>>> rtl/asdo_sqrt.sv
// ----------------------------------------------------------------------------
// asdo_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module asdo_sqrt #(
  parameter int unsigned InW = 48,
  parameter int unsigned TagW = 8
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                valid_i,
  input  wire logic [InW-1:0]      rad_i,
  input  wire logic [TagW-1:0]     tag_i,
  output logic                     valid_o,
  output logic [InW/2-1:0]         root_o,
  output logic [TagW-1:0]          tag_o
);
  localparam int unsigned OutW = InW / 2;

  logic [OutW:0]          vld_q;
  logic [InW-1:0]         rem_q  [OutW+1];
  logic [OutW-1:0]        root_q [OutW+1];
  logic [TagW-1:0]        tag_q  [OutW+1];

  always_comb begin
    vld_q[0]  = valid_i;
    rem_q[0]  = rad_i;
    root_q[0] = '0;
    tag_q[0]  = tag_i;
  end

  for (genvar s = 0; s < OutW; s++) begin : g_stage
    localparam int unsigned B = OutW - 1 - s;
    logic [InW+1:0] trial;
    logic [InW+1:0] remx;
    logic [OutW-1:0] rt_d;
    logic [InW-1:0] rem_d;
    always_comb begin
      trial = ({{(InW+2-OutW){1'b0}}, root_q[s]} << (B + 1))
            + ({{(InW+1){1'b0}}, 1'b1} << (2 * B));
      remx  = {2'b00, rem_q[s]};
      rt_d  = root_q[s];
      rem_d = rem_q[s];
      if (remx >= trial) begin
        rem_d = rem_q[s] - trial[InW-1:0];
        rt_d[B] = 1'b1;
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else begin
        vld_q[s+1] <= vld_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      rem_q[s+1]  <= rem_d;
      root_q[s+1] <= rt_d;
      tag_q[s+1]  <= tag_q[s];
    end
  end

  assign valid_o = vld_q[OutW];
  assign root_o  = root_q[OutW];
  assign tag_o   = tag_q[OutW];
endmodule
`default_nettype wire

>>> rtl/asdo_div.sv
// ----------------------------------------------------------------------------
// asdo_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module asdo_div #(
  parameter int unsigned NumW = 48,
  parameter int unsigned DenW = 32,
  parameter int unsigned TagW = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  input  wire logic [NumW-1:0]  num_i,
  input  wire logic [DenW-1:0]  den_i,
  input  wire logic [TagW-1:0]  tag_i,
  output logic                  valid_o,
  output logic [NumW-1:0]       quo_o,
  output logic [TagW-1:0]       tag_o
);
  logic [NumW:0]       vld_q;
  logic [NumW-1:0]     num_q [NumW+1];
  logic [DenW-1:0]     rem_q [NumW+1];
  logic [DenW-1:0]     den_q [NumW+1];
  logic [TagW-1:0]     tag_q [NumW+1];

  always_comb begin
    vld_q[0] = valid_i;
    num_q[0] = num_i;
    rem_q[0] = '0;
    den_q[0] = den_i;
    tag_q[0] = tag_i;
  end

  for (genvar s = 0; s < NumW; s++) begin : g_stage
    logic [DenW:0]   sh;
    logic [DenW-1:0] rem_d;
    logic [NumW-1:0] num_d;
    always_comb begin
      sh    = {rem_q[s], num_q[s][NumW-1]};
      num_d = {num_q[s][NumW-2:0], 1'b0};
      rem_d = sh[DenW-1:0];
      if (sh >= {1'b0, den_q[s]}) begin
        rem_d    = sh[DenW-1:0] - den_q[s];
        num_d[0] = 1'b1;
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else begin
        vld_q[s+1] <= vld_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      num_q[s+1] <= num_d;
      rem_q[s+1] <= rem_d;
      den_q[s+1] <= den_q[s];
      tag_q[s+1] <= tag_q[s];
    end
  end

  assign valid_o = vld_q[NumW];
  assign quo_o   = num_q[NumW];
  assign tag_o   = tag_q[NumW];
endmodule
`default_nettype wire

>>> rtl/analog_stick_deadzone_octagon_unit.sv
// ----------------------------------------------------------------------------
// analog_stick_deadzone_octagon_unit
// Analog stick conditioner: scaling, radial deadzone and octagonal gate.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: start_i with stick_select_i, raw_x_i, raw_y_i; a
//   transaction is taken at a clock edge with start_i high and busy_o low.
//   busy_o stays low, so one transaction may enter every cycle.
//   Result channel: done_o strobes for one cycle with stick_id_o,
//   stick_x_o and stick_y_o; the receiver cannot stall it.
//   Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i and
//   cfg_data_i; index 0 left deadzone, 1 right deadzone, others ignored.
//   Write only while no transaction is in flight.
//   Pipeline: 195 register stages in all: radius and gate roots (24 each),
//   rescale, axis and gate dividers (32, 48 and 56), and 11 single stages
//   around them.
//   Throughput: one transaction per cycle.
//   Reset clears all valid bits and sets both deadzones to 16.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "analog_stick_deadzone_octagon_unit_assert.svh"
module analog_stick_deadzone_octagon_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  output logic                              busy_o,
  input  wire logic                         stick_select_i,
  input  wire logic signed [15:0]           raw_x_i,
  input  wire logic signed [15:0]           raw_y_i,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [asdo_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [asdo_pkg::DzWidth-1:0] cfg_data_i,
  output logic                              done_o,
  output logic                              stick_id_o,
  output logic signed [7:0]                 stick_x_o,
  output logic signed [7:0]                 stick_y_o
);
  import asdo_pkg::*;

  localparam int unsigned TW = $bits(tag_t);

  logic [DzWidth-1:0] ldz_q, rdz_q;
  assign cfg_ready_o = 1'b1;
  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ldz_q <= DzReset;
      rdz_q <= DzReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == RegLeftDz)  ldz_q <= cfg_data_i;
      if (cfg_index_i == RegRightDz) rdz_q <= cfg_data_i;
    end
  end

  // Stage 0: magnitudes times full scale
  logic in_fire;
  logic [16:0] mx, my;
  assign in_fire = start_i;
  assign mx = raw_x_i[15] ? (17'h10000 - {1'b0, raw_x_i}) : {1'b0, raw_x_i};
  assign my = raw_y_i[15] ? (17'h10000 - {1'b0, raw_y_i}) : {1'b0, raw_y_i};

  logic s0_v_q;
  tag_t s0_tag_q;
  logic [21:0] s0_tx_q, s0_ty_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s0_v_q <= 1'b0;
    else         s0_v_q <= in_fire;
  end
  always_ff @(posedge clk_i) begin
    s0_tag_q <= '{sel: stick_select_i, neg_x: raw_x_i[15], neg_y: raw_y_i[15]};
    s0_tx_q  <= 22'(mx) * 22'(FullScale);
    s0_ty_q  <= 22'(my) * 22'(FullScale);
  end

  // Scale: t * 2^16 / (2^15 - 1) = u + u / (2^15 - 1) with u = 2t;
  // fold the high bits of u back in and correct by one compare
  function automatic logic [23:0] scale_q(logic [21:0] t);
    logic [22:0] u;
    logic [15:0] lo;
    u  = {t, 1'b0};
    lo = {8'd0, u[22:15]} + {1'b0, u[14:0]};
    return {1'b0, u} + {16'd0, u[22:15]} + {23'd0, lo >= 16'(RawScale)};
  endfunction

  logic sc_v_q;
  tag_t sc_tag_q;
  logic [23:0] sc_px_q, sc_py_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sc_v_q <= 1'b0;
    else         sc_v_q <= s0_v_q;
  end
  always_ff @(posedge clk_i) begin
    sc_tag_q <= s0_tag_q;
    sc_px_q  <= scale_q(s0_tx_q);
    sc_py_q  <= scale_q(s0_ty_q);
  end

  logic sc_v;
  logic [TW-1:0] sc_tag;
  assign sc_v   = sc_v_q;
  assign sc_tag = sc_tag_q;

  // Square stage
  logic [23:0] px, py;
  assign px = sc_px_q;
  assign py = sc_py_q;
  logic sq_v_q;
  logic [47:0] sqx_q, sqy_q;
  logic [47:0] sum_q;
  logic [23:0] sq_px_q, sq_py_q;
  tag_t sq_tag_q;
  logic sum_v_q;
  logic [23:0] sum_px_q, sum_py_q;
  tag_t sum_tag_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v_q <= 1'b0;
      sum_v_q <= 1'b0;
    end else begin
      sq_v_q <= sc_v;
      sum_v_q <= sq_v_q;
    end
  end
  always_ff @(posedge clk_i) begin
    sqx_q <= px * px;
    sqy_q <= py * py;
    sq_px_q <= px;
    sq_py_q <= py;
    sq_tag_q <= tag_t'(sc_tag);
    sum_q <= sqx_q + sqy_q;
    sum_px_q <= sq_px_q;
    sum_py_q <= sq_py_q;
    sum_tag_q <= sq_tag_q;
  end

  // Radius root (carry axes in tag)
  localparam int unsigned T1 = TW + 48;
  logic r1_v;
  logic [23:0] len;
  logic [T1-1:0] r1_tag;
  asdo_sqrt #(.InW(48), .TagW(T1)) u_rt1 (
    .clk_i, .rst_ni, .valid_i(sum_v_q), .rad_i(sum_q),
    .tag_i({sum_tag_q, sum_px_q, sum_py_q}),
    .valid_o(r1_v), .root_o(len), .tag_o(r1_tag));

  tag_t r1_t;
  logic [23:0] r1_px, r1_py;
  assign {r1_t, r1_px, r1_py} = r1_tag;

  // Deadzone setup
  logic [DzWidth-1:0] dz;
  logic [23:0] dq;
  logic dead, clamp;
  assign dz = r1_t.sel ? rdz_q : ldz_q;
  assign dq = {dz, 16'd0} & 24'hFFFFFF;
  assign dead = (dz >= DzWidth'(FullScale)) || (len == 24'd0) || (len < dq);
  assign clamp = len > 24'(FullScale << FracBits);

  logic d1_v_q, d1_dead_q, d1_clamp_q;
  logic [31:0] d1_num_q;
  logic [6:0]  d1_den_q;
  logic [23:0] d1_len_q, d1_px_q, d1_py_q;
  tag_t d1_tag_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) d1_v_q <= 1'b0;
    else         d1_v_q <= r1_v;
  end
  always_ff @(posedge clk_i) begin
    d1_dead_q  <= dead;
    d1_clamp_q <= clamp;
    d1_num_q   <= 32'(len - dq) * 32'(FullScale);
    d1_den_q   <= dead ? 7'd1 : 7'(7'(FullScale) - dz);
    d1_len_q   <= len;
    d1_px_q    <= r1_px;
    d1_py_q    <= r1_py;
    d1_tag_q   <= r1_t;
  end

  localparam int unsigned T2 = TW + 2 + 72;
  logic rd_v;
  logic [31:0] rq;
  logic [T2-1:0] rd_tag;
  asdo_div #(.NumW(32), .DenW(7), .TagW(T2)) u_rs (
    .clk_i, .rst_ni, .valid_i(d1_v_q), .num_i(d1_num_q), .den_i(d1_den_q),
    .tag_i({d1_tag_q, d1_dead_q, d1_clamp_q, d1_len_q, d1_px_q, d1_py_q}),
    .valid_o(rd_v), .quo_o(rq), .tag_o(rd_tag));

  tag_t rd_t;
  logic rd_dead, rd_clamp;
  logic [23:0] rd_len, rd_px, rd_py, rr;
  assign {rd_t, rd_dead, rd_clamp, rd_len, rd_px, rd_py} = rd_tag;
  assign rr = rd_clamp ? 24'(FullScale << FracBits) : rq[23:0];

  logic m2_v_q;
  logic [47:0] m2_nx_q, m2_ny_q;
  logic [23:0] m2_len_q;
  tag_t m2_tag_q;
  logic m2_dead_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m2_v_q <= 1'b0;
    else         m2_v_q <= rd_v;
  end
  always_ff @(posedge clk_i) begin
    m2_nx_q   <= rd_px * rr;
    m2_ny_q   <= rd_py * rr;
    m2_len_q  <= rd_dead ? 24'd1 : rd_len;
    m2_tag_q  <= rd_t;
    m2_dead_q <= rd_dead;
  end

  localparam int unsigned T3 = TW + 1;
  logic ax_v;
  logic [47:0] ax_q, ay_q;
  logic [T3-1:0] ax_tag;
  asdo_div #(.NumW(48), .DenW(24), .TagW(T3)) u_ax (
    .clk_i, .rst_ni, .valid_i(m2_v_q), .num_i(m2_nx_q), .den_i(m2_len_q),
    .tag_i({m2_tag_q, m2_dead_q}), .valid_o(ax_v), .quo_o(ax_q), .tag_o(ax_tag));
  logic unused_v1;
  logic [T3-1:0] unused_t1;
  asdo_div #(.NumW(48), .DenW(24), .TagW(T3)) u_ay (
    .clk_i, .rst_ni, .valid_i(m2_v_q), .num_i(m2_ny_q), .den_i(m2_len_q),
    .tag_i({m2_tag_q, m2_dead_q}), .valid_o(unused_v1), .quo_o(ay_q),
    .tag_o(unused_t1));

  tag_t ax_t;
  logic ax_dead;
  logic [23:0] bx, by;
  assign {ax_t, ax_dead} = ax_tag;
  assign bx = ax_dead ? 24'd0 : ax_q[23:0];
  assign by = ax_dead ? 24'd0 : ay_q[23:0];

  // Gate: squares and denominator
  logic g1_v_q, g2_v_q;
  logic [47:0] g1_sx_q, g1_sy_q, g2_sum_q;
  logic [23:0] g1_x_q, g1_y_q, g2_x_q, g2_y_q;
  logic [31:0] g1_den_q, g2_den_q;
  tag_t g1_tag_q, g2_tag_q;
  logic [23:0] big, sml;
  assign big = (bx > by) ? bx : by;
  assign sml = (bx > by) ? by : bx;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g1_v_q <= 1'b0;
      g2_v_q <= 1'b0;
    end else begin
      g1_v_q <= ax_v;
      g2_v_q <= g1_v_q;
    end
  end
  always_ff @(posedge clk_i) begin
    g1_sx_q  <= bx * bx;
    g1_sy_q  <= by * by;
    g1_x_q   <= bx;
    g1_y_q   <= by;
    g1_den_q <= 32'(big) * 32'(GateMajor) + 32'(sml) * 32'(GateMinor);
    g1_tag_q <= ax_t;
    g2_sum_q <= g1_sx_q + g1_sy_q;
    g2_x_q   <= g1_x_q;
    g2_y_q   <= g1_y_q;
    g2_den_q <= g1_den_q;
    g2_tag_q <= g1_tag_q;
  end

  localparam int unsigned T4 = TW + 80;
  logic r2_v;
  logic [23:0] l2;
  logic [T4-1:0] r2_tag;
  asdo_sqrt #(.InW(48), .TagW(T4)) u_rt2 (
    .clk_i, .rst_ni, .valid_i(g2_v_q), .rad_i(g2_sum_q),
    .tag_i({g2_tag_q, g2_x_q, g2_y_q, g2_den_q}),
    .valid_o(r2_v), .root_o(l2), .tag_o(r2_tag));

  tag_t r2_t;
  logic [23:0] r2_x, r2_y;
  logic [31:0] r2_den;
  assign {r2_t, r2_x, r2_y, r2_den} = r2_tag;

  logic h1_v_q, h2_v_q;
  logic [31:0] h1_x_q, h1_y_q;
  logic [23:0] h1_l_q, h2_x_q, h2_y_q;
  logic [55:0] h2_nx_q, h2_ny_q;
  logic [31:0] h1_den_q, h2_den_q;
  tag_t h1_tag_q, h2_tag_q;
  logic [23:0] h1_rx_q, h1_ry_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h1_v_q <= 1'b0;
      h2_v_q <= 1'b0;
    end else begin
      h1_v_q <= r2_v;
      h2_v_q <= h1_v_q;
    end
  end
  always_ff @(posedge clk_i) begin
    h1_x_q   <= 32'(r2_x) * 32'(GateMajor);
    h1_y_q   <= 32'(r2_y) * 32'(GateMajor);
    h1_l_q   <= l2;
    h1_den_q <= (r2_den == 32'd0) ? 32'd1 : r2_den;
    h1_tag_q <= r2_t;
    h1_rx_q  <= r2_x;
    h1_ry_q  <= r2_y;
    h2_nx_q  <= 56'(h1_x_q) * 56'(h1_l_q);
    h2_ny_q  <= 56'(h1_y_q) * 56'(h1_l_q);
    h2_den_q <= h1_den_q;
    h2_tag_q <= h1_tag_q;
    h2_x_q   <= h1_rx_q;
    h2_y_q   <= h1_ry_q;
  end

  localparam int unsigned T5 = TW + 1 + 48;
  logic gx_v;
  logic [55:0] gx, gy;
  logic [T5-1:0] gx_tag;
  logic both;
  assign both = (h2_x_q != 24'd0) && (h2_y_q != 24'd0);
  asdo_div #(.NumW(56), .DenW(32), .TagW(T5)) u_gx (
    .clk_i, .rst_ni, .valid_i(h2_v_q), .num_i(h2_nx_q), .den_i(h2_den_q),
    .tag_i({h2_tag_q, both, h2_x_q, h2_y_q}), .valid_o(gx_v), .quo_o(gx),
    .tag_o(gx_tag));
  logic unused_v2;
  logic [T5-1:0] unused_t2;
  asdo_div #(.NumW(56), .DenW(32), .TagW(T5)) u_gy (
    .clk_i, .rst_ni, .valid_i(h2_v_q), .num_i(h2_ny_q), .den_i(h2_den_q),
    .tag_i({h2_tag_q, both, h2_x_q, h2_y_q}), .valid_o(unused_v2), .quo_o(gy),
    .tag_o(unused_t2));

  tag_t o_t;
  logic o_both;
  logic [23:0] o_x, o_y, fx, fy;
  logic [7:0] wx, wy;
  assign {o_t, o_both, o_x, o_y} = gx_tag;
  assign fx = o_both ? gx[23:0] : o_x;
  assign fy = o_both ? gy[23:0] : o_y;
  assign wx = fx[23:16];
  assign wy = fy[23:16];

  logic out_v_q;
  logic out_id_q;
  logic [7:0] out_x_q, out_y_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else         out_v_q <= gx_v;
  end
  always_ff @(posedge clk_i) begin
    out_id_q <= o_t.sel;
    out_x_q  <= o_t.neg_x ? (8'd0 - wx) : wx;
    out_y_q  <= o_t.neg_y ? wy : (8'd0 - wy);
  end

  assign done_o     = out_v_q;
  assign stick_id_o = out_id_q;
  assign stick_x_o  = out_x_q;
  assign stick_y_o  = out_y_q;

  `ASDO_ASSERT_NXT(a_in_s0, clk_i, rst_ni, in_fire, s0_v_q)
  `ASDO_ASSERT_IMP(a_lanes, clk_i, rst_ni, ax_v, ax_v == unused_v1)
  `ASDO_ASSERT_IMP(a_gate_lanes, clk_i, rst_ni, gx_v, gx_v == unused_v2)
  `ASDO_ASSERT_NXT(a_out, clk_i, rst_ni, gx_v, done_o)
endmodule
`default_nettype wire

>>> test/analog_stick_deadzone_octagon_unit_tb.sv
// ----------------------------------------------------------------------------
// analog_stick_deadzone_octagon_unit_tb
// Drives stick samples through the conditioner under several deadzone
// settings, with random gaps, and checks every result against a table
// entry or a built-in fixed-point model of scaling, radial deadzone and gate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module analog_stick_deadzone_octagon_unit_tb;
  import asdo_pkg::*;

  typedef struct {
    logic              sel;
    logic signed [7:0] x;
    logic signed [7:0] y;
  } stick_pos_t;

  typedef struct {
    logic               sel;
    logic signed [15:0] rx;
    logic signed [15:0] ry;
    bit                 fixed;
    logic signed [7:0]  ex;
    logic signed [7:0]  ey;
  } sample_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic stick_select_i = 1'b0;
  logic signed [15:0] raw_x_i = '0;
  logic signed [15:0] raw_y_i = '0;
  logic cfg_valid_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [DzWidth-1:0] cfg_data_i = '0;
  logic busy_o, cfg_ready_o, done_o, stick_id_o;
  logic signed [7:0] stick_x_o, stick_y_o;

  analog_stick_deadzone_octagon_unit i_dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  logic [DzWidth-1:0] dz_left = DzReset, dz_right = DzReset;
  stick_pos_t pending_pos[$];
  stick_pos_t fixed_pos[$];
  int mismatches = 0;
  int quiet_cycles = 0;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic stick_pos_t condition_stick(logic sel, logic signed [15:0] rx,
                                                 logic signed [15:0] ry);
    stick_pos_t p;
    longint unsigned mx, my, px, py, len, dz, dq, fullq, r, big, lil, l2, den, wx, wy;
    mx = rx[15] ? 64'h10000 - {48'd0, rx} : {48'd0, rx};
    my = ry[15] ? 64'h10000 - {48'd0, ry} : {48'd0, ry};
    dz = sel ? dz_right : dz_left;
    px = ((mx * FullScale) << FracBits) / RawScale;
    py = ((my * FullScale) << FracBits) / RawScale;
    len = int_sqrt(px * px + py * py);
    dq = dz << FracBits;
    fullq = longint'(FullScale) << FracBits;
    if (dz >= FullScale || len == 0 || len < dq) begin
      px = 0;
      py = 0;
    end else begin
      r = (len > fullq) ? fullq : ((len - dq) * FullScale) / (FullScale - dz);
      px = px * r / len;
      py = py * r / len;
    end
    if (px != 0 && py != 0) begin
      big = px > py ? px : py;
      lil = px > py ? py : px;
      l2 = int_sqrt(px * px + py * py);
      den = GateMajor * big + GateMinor * lil;
      px = px * GateMajor * l2 / den;
      py = py * GateMajor * l2 / den;
    end
    wx = px >> FracBits;
    wy = py >> FracBits;
    p.sel = sel;
    p.x = rx[15] ? -wx[7:0] : wx[7:0];
    p.y = ry[15] ? wy[7:0] : -wy[7:0];
    return p;
  endfunction

  // sample at the falling edge: values are those the next rising edge sees
  always @(negedge clk_i) begin
    stick_pos_t exp_pos;
    bit moved;
    moved = 1'b0;
    if (rst_ni && cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == RegLeftDz) dz_left = cfg_data_i;
      else if (cfg_index_i == RegRightDz) dz_right = cfg_data_i;
    end
    if (rst_ni && start_i && !busy_o) begin
      moved = 1'b1;
      if (fixed_pos.size() != 0) pending_pos.push_back(fixed_pos.pop_front());
      else pending_pos.push_back(condition_stick(stick_select_i, raw_x_i, raw_y_i));
    end
    if (rst_ni && done_o) begin
      moved = 1'b1;
      if (pending_pos.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result id=%0d x=%0d y=%0d",
                                       stick_id_o, stick_x_o, stick_y_o);
      end else begin
        exp_pos = pending_pos.pop_front();
        if (exp_pos.sel !== stick_id_o || exp_pos.x !== stick_x_o ||
            exp_pos.y !== stick_y_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected id=%0d x=%0d y=%0d, got id=%0d x=%0d y=%0d",
                     exp_pos.sel, exp_pos.x, exp_pos.y, stick_id_o, stick_x_o, stick_y_o);
        end
      end
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_sample(logic sel, logic signed [15:0] rx, logic signed [15:0] ry,
                             bit no_gaps);
    int gap;
    bit taken;
    gap = no_gaps ? 0 : int'($urandom_range(0, 7));
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    stick_select_i <= sel;
    raw_x_i <= rx;
    raw_y_i <= ry;
    do begin
      @(negedge clk_i);
      taken = !busy_o;
      @(posedge clk_i);
    end while (!taken);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (pending_pos.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_deadzone(logic [CfgIdxW-1:0] idx, logic [DzWidth-1:0] val);
    bit taken;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do begin
      @(negedge clk_i);
      taken = cfg_ready_o;
      @(posedge clk_i);
    end while (!taken);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] random_axis(int mode);
    int m;
    case (mode)
      0: return 16'($urandom);
      1: begin
        m = int'($urandom_range(0, 12000));
        return 16'($urandom_range(0, 1) ? -m : m);
      end
      2: return 16'($urandom_range(0, 1) ? 32'h8000 + $urandom_range(0, 40)
                                         : 32'h7fff - $urandom_range(0, 40));
      default: begin
        m = int'($urandom_range(0, 300));
        return 16'($urandom_range(0, 1) ? -m : m);
      end
    endcase
  endfunction

  sample_row_t directed_rows[] = '{
    '{0, 16'sd0, 16'sd0, 1, 8'sd0, 8'sd0},
    '{0, 16'sd32767, 16'sd0, 1, 8'sd85, 8'sd0},
    '{1, -16'sd32768, 16'sd0, 1, -8'sd85, 8'sd0},
    '{0, 16'sd0, 16'sd32767, 1, 8'sd0, -8'sd85},
    '{1, 16'sd0, -16'sd32768, 1, 8'sd0, 8'sd85},
    '{0, 16'sd100, -16'sd100, 1, 8'sd0, 8'sd0},
    '{1, -16'sd1, 16'sd1, 1, 8'sd0, 8'sd0},
    '{0, 16'sd32767, 16'sd32767, 0, 0, 0},
    '{1, -16'sd32768, -16'sd32768, 0, 0, 0},
    '{0, -16'sd32768, 16'sd32767, 0, 0, 0},
    '{1, 16'sd6168, 16'sd0, 0, 0, 0},
    '{0, 16'sd6169, 16'sd1, 0, 0, 0},
    '{1, 16'sd4400, 16'sd4400, 0, 0, 0},
    '{0, 16'sd20000, -16'sd9000, 0, 0, 0},
    '{1, -16'sd12345, 16'sd30000, 0, 0, 0},
    '{0, 16'sh5555, 16'shaaaa, 0, 0, 0},
    '{1, 16'shaaaa, 16'sh5555, 0, 0, 0},
    '{0, 16'sd1, 16'sd32767, 0, 0, 0}
  };

  initial begin
    stick_pos_t fp;
    int dz_plan[6][2] = '{'{16, 16}, '{0, 84}, '{84, 0}, '{85, 127}, '{-1, -1}, '{-1, -1}};
    int mode;
    bit no_gaps;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed_rows[i]) begin
      if (directed_rows[i].fixed) begin
        fp.sel = directed_rows[i].sel;
        fp.x = directed_rows[i].ex;
        fp.y = directed_rows[i].ey;
      end else begin
        fp = condition_stick(directed_rows[i].sel, directed_rows[i].rx, directed_rows[i].ry);
      end
      fixed_pos.push_back(fp);
      send_sample(directed_rows[i].sel, directed_rows[i].rx, directed_rows[i].ry, i % 3 == 0);
    end
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      write_deadzone(RegLeftDz, DzWidth'(dz_plan[ph][0] < 0 ? int'($urandom_range(0, 84))
                                                             : dz_plan[ph][0]));
      write_deadzone(RegRightDz, DzWidth'(dz_plan[ph][1] < 0 ? int'($urandom_range(0, 127))
                                                              : dz_plan[ph][1]));
      no_gaps = (ph == 2);
      for (int n = 0; n < 300; n++) begin
        mode = int'($urandom_range(0, 3));
        send_sample(1'($urandom_range(0, 1)), random_axis(mode),
                    random_axis(int'($urandom_range(0, 3))),
                    no_gaps || (n / 50) % 3 == 1);
      end
      drain();
    end
    repeat (600) @(posedge clk_i);
    if (mismatches == 0 && pending_pos.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
